// ===== hw/rtl/erx_pkg.sv =====
// erx_pkg: shared types and constants for the escaped frame receiver.
// Configuration register set, register indexes and the result beat layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package erx_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned VALUE_W  = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESC_CODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ESC_XOR    = 2'd2;

	// Register reset values
	localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h02;
	localparam logic [BYTE_W-1:0] ESC_CODE_RST   = 8'h7D;
	localparam logic [BYTE_W-1:0] ESC_XOR_RST    = 8'h20;

	typedef struct packed {
		logic [BYTE_W-1:0] start_code;
		logic [BYTE_W-1:0] esc_code;
		logic [BYTE_W-1:0] esc_xor;
	} cfg_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               checksum_ok;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/escaped_frame_receiver.sv =====
// escaped_frame_receiver: top level of the byte-stuffed frame receiver.
// Instantiates erx_cfg, erx_deframe and erx_out_reg; depends on erx_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The receiver takes one raw serial byte per input beat and returns one result
// beat per complete frame: head byte, two payload bytes (either may be sent as
// escape byte plus masked byte), then an additive checksum byte that covers every
// raw byte after the head. The result carries the big-endian 16-bit payload and
// checksum_ok; a frame whose checksum mismatches is still reported, with the
// flag clear. Bytes outside a frame that are not the head byte are dropped. A
// byte is accepted in every cycle unless the input side stalls (see below): it
// lands in an input register, small compare, XOR and 8-bit add logic updates the
// frame state, and the checksum beat writes the result register, from which the
// consumer takes the result beat. The input side stalls only while a checksum
// byte sits in the input register and the result register holds a beat that
// the consumer is not taking. The start code, escape code and escape mask
// registers are written through cfg_wen/cfg_idx/cfg_wdata; the user must write
// them only while no frame is in flight, as the block does not enforce this.
module escaped_frame_receiver (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           cfg_wen,
	input  wire logic [erx_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [erx_pkg::BYTE_W-1:0]     cfg_wdata,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [erx_pkg::BYTE_W-1:0]     rx_byte,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [erx_pkg::VALUE_W-1:0]         value,
	output logic                                checksum_ok
);
	import erx_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t out_res;
	logic    res_valid;
	logic    res_ready;

	// Register bank; values take effect from the next byte processed
	erx_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input register plus frame state: unescape, sum, capture payload
	erx_deframe u_deframe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_byte   (rx_byte),
		.in_ready  (in_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// Hold the finished result until the consumer takes the beat
	erx_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.out_valid (out_valid),
		.out_res   (out_res),
		.out_ready (out_ready)
	);

	assign value       = out_res.value;
	assign checksum_ok = out_res.checksum_ok;

endmodule

`default_nettype wire

// ===== hw/rtl/erx_cfg.sv =====
// erx_cfg: configuration register bank of the escaped frame receiver.
// Depends on erx_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module erx_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [erx_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [erx_pkg::BYTE_W-1:0]      cfg_wdata,
	output erx_pkg::cfg_t                        cfg
);
	import erx_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code <= START_CODE_RST;
			cfg_q.esc_code   <= ESC_CODE_RST;
			cfg_q.esc_xor    <= ESC_XOR_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_START_CODE: cfg_q.start_code <= cfg_wdata;
				REG_ESC_CODE:   cfg_q.esc_code   <= cfg_wdata;
				REG_ESC_XOR:    cfg_q.esc_xor    <= cfg_wdata;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/erx_deframe.sv =====
// erx_deframe: input byte register and deframing state machine.
// Unescapes payload, keeps the running sum and forms one result per frame.
// Depends on erx_pkg for cfg_t and result_t.
`timescale 1ns / 1ps
`default_nettype none

module erx_deframe (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire erx_pkg::cfg_t               cfg,
	input  wire logic                        in_valid,
	input  wire logic [erx_pkg::BYTE_W-1:0]  in_byte,
	output logic                             in_ready,
	output logic                             res_valid,
	output erx_pkg::result_t                 res,
	input  wire logic                        res_ready
);
	import erx_pkg::*;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_FIRST  = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;
	localparam logic [1:0] PH_CHECK  = 2'd3;

	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [1:0]        phase_q;
	logic              esc_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] high_q;
	logic [BYTE_W-1:0] low_q;

	logic              fire;
	logic              store;
	logic [BYTE_W-1:0] payload;

	// A checksum byte needs room in the result register; others always proceed
	assign fire     = vld_s1 && ((phase_q != PH_CHECK) || res_ready);
	assign in_ready = !vld_s1 || fire;

	assign res_valid = vld_s1 && (phase_q == PH_CHECK);
	// value first, then checksum_ok
	assign res       = {high_q, low_q, (byte_s1 == sum_q)};

	assign payload = esc_q ? (byte_s1 ^ cfg.esc_xor) : byte_s1;
	assign store   = esc_q || (byte_s1 != cfg.esc_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			esc_q   <= 1'b0;
			sum_q   <= '0;
			high_q  <= '0;
			low_q   <= '0;
		end else if (fire) begin
			case (phase_q)
				PH_IDLE: begin
					if (byte_s1 == cfg.start_code) begin
						phase_q <= PH_FIRST;
						esc_q   <= 1'b0;
						sum_q   <= '0;
					end
				end
				PH_FIRST, PH_SECOND: begin
					sum_q <= sum_q + byte_s1;
					esc_q <= !store;
					if (store) begin
						if (phase_q == PH_FIRST) begin
							high_q  <= payload;
							phase_q <= PH_SECOND;
						end else begin
							low_q   <= payload;
							phase_q <= PH_CHECK;
						end
					end
				end
				default: begin
					phase_q <= PH_IDLE;
					esc_q   <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/erx_out_reg.sv =====
// erx_out_reg: result register between the deframer and the output channel.
// Depends on erx_pkg for result_t.
`timescale 1ns / 1ps
`default_nettype none

module erx_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_valid,
	input  wire erx_pkg::result_t  res,
	output logic                   res_ready,
	output logic                   out_valid,
	output erx_pkg::result_t       out_res,
	input  wire logic              out_ready
);
	import erx_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign res_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

`default_nettype wire
